// ----- src/seqkw_pkg.sv -----
// Shared types and constants for the stereo equalizer, karaoke and widener block.
// No dependencies.
package seqkw_pkg;

  localparam int SampleWidth  = 16;
  localparam int CoefWidth    = 24;
  localparam int CoefsPerBand = 5;
  localparam int AmountWidth  = 17;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [2:0] {
    CFG_STEREO_MODE    = 3'd0,
    CFG_BAND_ENABLE    = 3'd1,
    CFG_KARAOKE_AMOUNT = 3'd2,
    CFG_SPATIAL_ENABLE = 3'd3,
    CFG_SPATIAL_DEPTH  = 3'd4
  } cfg_idx_t;

  // Start and done pulses between the sequencer and the serial multiplier.
  typedef struct packed {
    logic start;
    logic done;
  } mul_ctl_t;

endpackage

// ----- src/seqkw_smul.sv -----
// Shift-and-add signed multiplier, one multiplier bit per cycle.
// Depends on seqkw_pkg for the control struct.
module seqkw_smul import seqkw_pkg::*; #(
  parameter int AW = 48,
  parameter int BW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output mul_ctl_t             ctl,
  output logic signed [AW+BW-1:0] p
);
  localparam int CW = $clog2(BW + 1);
  logic signed [AW+BW-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [BW-1:0] mplier_r, mplier_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplier_nxt = mplier_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = (AW+BW)'(a);
      mplier_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The top bit of a two's complement multiplier carries negative weight.
      if (mplier_r[0]) begin
        if (cnt_r == CW'(BW - 1)) acc_nxt = acc_r - mcand_r;
        else acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplier_r <= mplier_nxt;
  end

  assign p = acc_r;
  assign ctl.start = start;
  assign ctl.done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("multiplier done without run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !done_r |=> busy_r || done_r) else $error("multiplier dropped run");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("multiplier started while running");
endmodule

// ----- src/stereo_eq_karaoke_widener.sv -----
// Top level of the stereo equalizer with karaoke centre cut and widener.
// Depends on seqkw_pkg and seqkw_smul.
// A coefficient write is taken while the block is idle and the block stays ready.
// Each serial multiply steps through the 24 multiplier bits and then raises done. A
// stereo frame takes longer for each enabled band and for karaoke and widening when
// enabled. One serial multiplier does all of this, so a new frame is taken only after
// the result word of the last one has been taken.
// Reset (synchronous, active low) restores the registers, marks every coefficient
// as identity through per-entry valid bits and clears the delay valid bits.
module stereo_eq_karaoke_widener import seqkw_pkg::*; #(
  parameter int NUM_BANDS      = 10,
  parameter int COEF_FRAC_BITS = 20,
  parameter int STATE_WIDTH    = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic signed [15:0]     in_left_sample,
  input  logic signed [15:0]     in_right_sample,
  input  logic [3:0]             in_band_number,
  input  logic [2:0]             in_coef_select,
  input  logic signed [23:0]     in_coef_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     out_left_out,
  output logic signed [15:0]     out_right_out,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [16:0]            cfg_data
);
  localparam int F    = COEF_FRAC_BITS;
  localparam int SW   = STATE_WIDTH;
  localparam int AW   = SW + 20;           // multiplicand width covers every operand
  localparam int PW   = AW + CoefWidth;
  localparam int BW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int NE   = NUM_BANDS * CoefsPerBand;
  localparam int NEW  = $clog2(NE);
  localparam int ND   = NUM_BANDS * 4;
  localparam int NDW  = $clog2(ND);
  localparam logic signed [PW-1:0] SigMax = (PW'(1) <<< (F + 3)) - 1;
  localparam logic signed [PW-1:0] SigMin = -(PW'(1) <<< (F + 3));
  localparam logic signed [PW-1:0] StMax  = (PW'(1) <<< (SW - 1)) - 1;
  localparam logic signed [PW-1:0] StMin  = -(PW'(1) <<< (SW - 1));
  localparam logic signed [PW-1:0] OneQ   = PW'(1) <<< F;
  localparam logic signed [CoefWidth-1:0] CoefOne =
      (F >= CoefWidth - 1) ? {1'b0, {(CoefWidth-1){1'b1}}} : CoefWidth'(1 << F);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001, S_LOAD = 13'b0000000000010,
    S_BAND = 13'b0000000000100, S_RD   = 13'b0000000001000,
    S_MUL  = 13'b0000000010000, S_WAIT = 13'b0000000100000,
    S_ACC  = 13'b0000001000000, S_KAR  = 13'b0000010000000,
    S_SPA  = 13'b0000100000000, S_PCM  = 13'b0001000000000,
    S_OUT  = 13'b0010000000000, S_WID  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  // Configuration registers.
  logic        stereo_r;
  logic [9:0]  band_en_r;
  logic [16:0] kar_r, depth_r;
  logic        spat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b1; band_en_r <= '0; kar_r <= '0; spat_r <= 1'b0;
      depth_r <= 17'd45875;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEREO_MODE:    stereo_r <= cfg_data[0];
        CFG_BAND_ENABLE:    band_en_r <= cfg_data[9:0];
        CFG_KARAOKE_AMOUNT: kar_r <= cfg_data;
        CFG_SPATIAL_ENABLE: spat_r <= cfg_data[0];
        CFG_SPATIAL_DEPTH:  depth_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficient and delay memories; valid bits stand in for their reset values.
  logic signed [CoefWidth-1:0] coef_mem [NE];
  logic [NE-1:0]               coef_vld_r;
  logic signed [SW-1:0]        dly_mem [ND];
  logic [ND-1:0]               dly_vld_r;
  logic signed [CoefWidth-1:0] coef_rd_r;
  logic signed [SW-1:0]        dly_rd_r;
  logic                        coef_rv_r, dly_rv_r;
  logic [NEW-1:0]              coef_ra;
  logic [NDW-1:0]              dly_ra, dly_wa;
  logic                        dly_we;
  logic signed [SW-1:0]        dly_wd;
  logic                        coef_we;
  logic [NEW-1:0]              coef_wa;

  assign coef_we = in_valid && in_ready && in_op &&
                   (32'(in_band_number) < NUM_BANDS) && (in_coef_select <= COEF_A2);
  assign coef_wa = NEW'(32'(in_band_number) * CoefsPerBand + 32'(in_coef_select));

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_wa] <= in_coef_value;
    coef_rd_r <= coef_mem[coef_ra];
    coef_rv_r <= coef_vld_r[coef_ra];
    if (dly_we) dly_mem[dly_wa] <= dly_wd;
    dly_rd_r <= dly_mem[dly_ra];
    dly_rv_r <= dly_vld_r[dly_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0; dly_vld_r <= '0;
    end else begin
      if (coef_we) coef_vld_r[coef_wa] <= 1'b1;
      if (dly_we) dly_vld_r[dly_wa] <= 1'b1;
    end
  end

  // Sequencer state.
  state_t state_r, state_nxt;
  logic signed [PW-1:0] l_r, l_nxt, r_r, r_nxt, x_r, x_nxt, y_r, y_nxt;
  logic signed [PW-1:0] t1_r, t1_nxt;
  logic [BW-1:0] band_r, band_nxt;
  logic ch_r, ch_nxt;                     // channel under work, 0 left
  logic [2:0] step_r, step_nxt;           // step within a biquad or a stage
  logic signed [15:0] ol_r, ol_nxt, or_r, or_nxt;
  logic outv_r, outv_nxt;
  logic signed [AW-1:0] ma_r, ma_nxt;
  logic signed [CoefWidth-1:0] mb_r, mb_nxt;
  logic mstart;
  logic signed [PW-1:0] prod;
  mul_ctl_t mctl;
  logic signed [PW-1:0] z1_r, z1_nxt;     // old z1, then the b1 and b2 products, during a biquad
  logic [1:0] stage_r, stage_nxt;         // 0 biquad or output multiply, 1 karaoke, 2 widening, 3 output

  seqkw_smul #(.AW(AW), .BW(CoefWidth)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma_r), .b(mb_r), .ctl(mctl), .p(prod)
  );

  function automatic logic signed [PW-1:0] fsat(input logic signed [PW-1:0] v,
      input logic signed [PW-1:0] lo, input logic signed [PW-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [PW-1:0] frnd(input logic signed [PW-1:0] v, input int n);
    return (v + (PW'(1) <<< (n - 1))) >>> n;
  endfunction

  logic [16:0] kcl, dcl;
  logic [16:0] kc;
  logic [16:0] wq;
  assign kcl = (kar_r > 17'd65536) ? 17'd65536 : kar_r;
  assign dcl = (depth_r > 17'd65536) ? 17'd65536 : depth_r;
  assign kc  = 17'd65536 - kcl;
  // w - 1 for widening; a small constant divide done by the table-free reciprocal.
  logic [23:0] d17;
  assign d17 = 24'(dcl) * 24'd17 + 24'd10;
  assign wq  = 17'(({16'd0, d17} * 40'd838861) >> 24);

  logic [1:0] nxt_band_found;
  logic [15:0] pcm_nxt;
  logic signed [PW-1:0] cl;
  logic [PW-1:0] mag;

  always_comb begin
    // Next enabled band at or after band_r, searched one band per cycle in S_BAND.
    nxt_band_found = 2'd0;
    if (32'(band_r) < 10 && band_en_r[4'(band_r)]) nxt_band_found = 2'd1;
  end

  assign cl  = fsat(y_r, -OneQ, OneQ);
  assign mag = (cl < 0) ? PW'(-cl) : PW'(cl);
  assign pcm_nxt = (t1_r[PW-1]) ? 16'(-(prod >>> F)) : 16'(prod >>> F);

  assign in_ready = (state_r == S_IDLE) && !outv_r;

  always_comb begin
    state_nxt = state_r; l_nxt = l_r; r_nxt = r_r; x_nxt = x_r; y_nxt = y_r;
    t1_nxt = t1_r; band_nxt = band_r; ch_nxt = ch_r; step_nxt = step_r;
    ol_nxt = ol_r; or_nxt = or_r; outv_nxt = outv_r; ma_nxt = ma_r; mb_nxt = mb_r;
    z1_nxt = z1_r; stage_nxt = stage_r; mstart = 1'b0;
    coef_ra = NEW'(32'(band_r) * CoefsPerBand + 32'(step_r));
    dly_ra = NDW'(32'(band_r) * 4 + 32'(ch_r) * 2 + ((step_r == 3'd0) ? 0 : 1));
    dly_we = 1'b0; dly_wa = NDW'(32'(band_r) * 4 + 32'(ch_r) * 2); dly_wd = '0;
    if (outv_r && out_ready) outv_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready && !in_op) begin
        l_nxt = (PW'(in_left_sample) <<< F) >>> 15;
        r_nxt = (PW'(in_right_sample) <<< F) >>> 15;
        band_nxt = '0; ch_nxt = 1'b0;
        if (!stereo_r) begin
          y_nxt = (PW'(in_left_sample) <<< F) >>> 15; stage_nxt = 2'd3; ch_nxt = 1'b1;
          state_nxt = S_PCM;
        end else state_nxt = S_BAND;
      end
      S_BAND: begin
        if (nxt_band_found != 2'd0) begin
          step_nxt = 3'd0; x_nxt = ch_r ? r_r : l_r; state_nxt = S_RD;
          stage_nxt = 2'd0;
        end else if (32'(band_r) >= NUM_BANDS - 1) begin
          state_nxt = S_KAR;
        end else band_nxt = band_r + 1'b1;
      end
      S_RD: state_nxt = S_LOAD;          // coefficient and delay read in flight
      S_LOAD: begin
        // Multiply x or y by coefficient step_r: steps 0..2 use x, 3..4 use y.
        ma_nxt = AW'((step_r >= 3'd3) ? y_r : x_r);
        mb_nxt = coef_rv_r ? coef_rd_r : ((step_r == 3'd0) ? CoefOne : '0);
        if (step_r == 3'd0) z1_nxt = dly_rv_r ? PW'(dly_rd_r) : '0;
        if (step_r == 3'd1) t1_nxt = dly_rv_r ? PW'(dly_rd_r) : '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin mstart = 1'b1; state_nxt = S_WAIT; end
      S_WAIT: if (mctl.done) state_nxt = S_ACC;
      S_ACC: begin
        unique case (coef_sel_t'(step_r))
          COEF_B0: begin
            y_nxt = fsat(frnd(prod, F) + z1_r, SigMin, SigMax);
            step_nxt = 3'd1; state_nxt = S_RD;
          end
          COEF_B1: begin x_nxt = x_r; z1_nxt = prod; step_nxt = 3'd3; state_nxt = S_RD; end
          COEF_A1: begin
            dly_we = 1'b1;
            dly_wd = SW'(fsat(frnd(z1_r - prod, F) + t1_r, StMin, StMax));
            step_nxt = 3'd2; state_nxt = S_RD;
          end
          COEF_B2: begin z1_nxt = prod; step_nxt = 3'd4; state_nxt = S_RD; end
          COEF_A2: begin
            dly_we = 1'b1; dly_wa = NDW'(32'(band_r) * 4 + 32'(ch_r) * 2 + 1);
            dly_wd = SW'(fsat(frnd(z1_r - prod, F), StMin, StMax));
            if (ch_r) r_nxt = y_r; else l_nxt = y_r;
            ch_nxt = ~ch_r;
            if (ch_r) begin
              if (32'(band_r) >= NUM_BANDS - 1) state_nxt = S_KAR;
              else begin band_nxt = band_r + 1'b1; state_nxt = S_BAND; end
            end else state_nxt = S_BAND;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_KAR: begin
        // Karaoke: multiply the channel sum by c, then form the two outputs.
        if (kcl == 17'd0) state_nxt = S_SPA;
        else begin
          ma_nxt = AW'(l_r + r_r); mb_nxt = CoefWidth'(kc); step_nxt = 3'd5;
          mstart = 1'b0; state_nxt = S_FIN; stage_nxt = 2'd1;
        end
      end
      S_SPA: begin
        if (!spat_r || dcl == 17'd0) begin
          y_nxt = l_r; ch_nxt = 1'b0; stage_nxt = 2'd3; state_nxt = S_PCM;
        end else begin
          ma_nxt = AW'(l_r - r_r); mb_nxt = CoefWidth'(18'(wq) + 18'd65536);
          state_nxt = S_FIN; stage_nxt = 2'd2;
        end
      end
      S_FIN: begin mstart = 1'b1; state_nxt = S_WID; end
      S_WID: if (mctl.done) begin
        if (stage_r == 2'd1) begin
          l_nxt = fsat(frnd(prod + ((l_r - r_r) <<< 16), 17), SigMin, SigMax);
          r_nxt = fsat(frnd(prod - ((l_r - r_r) <<< 16), 17), SigMin, SigMax);
          state_nxt = S_SPA;
        end else if (stage_r == 2'd2) begin
          l_nxt = fsat(frnd(((l_r + r_r) <<< 16) + prod, 17), SigMin, SigMax);
          r_nxt = fsat(frnd(((l_r + r_r) <<< 16) - prod, 17), SigMin, SigMax);
          y_nxt = fsat(frnd(((l_r + r_r) <<< 16) + prod, 17), SigMin, SigMax);
          ch_nxt = 1'b0; stage_nxt = 2'd3; state_nxt = S_PCM;
        end
      end
      S_PCM: begin
        // Output scaling: magnitude times 32767, shifted, sign restored.
        ma_nxt = AW'(mag); mb_nxt = CoefWidth'(32767); t1_nxt = cl;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        mstart = 1'b1; state_nxt = S_WID; stage_nxt = 2'd0;
      end
      default: state_nxt = S_IDLE;
    endcase
    // Output scaling completion shares the S_WID wait with stage code zero
    // once the band loop is finished.
    if (state_r == S_WID && stage_r == 2'd0 && mctl.done) begin
      if (!ch_r) begin
        ol_nxt = pcm_nxt;
        if (!stereo_r) begin
          or_nxt = pcm_nxt; outv_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          ch_nxt = 1'b1; y_nxt = r_r; stage_nxt = 2'd3; state_nxt = S_PCM;
        end
      end else begin
        if (stereo_r) or_nxt = pcm_nxt; else begin ol_nxt = pcm_nxt; or_nxt = pcm_nxt; end
        outv_nxt = 1'b1; state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; outv_r <= 1'b0; band_r <= '0; ch_r <= 1'b0; step_r <= '0;
      stage_r <= '0;
    end else begin
      state_r <= state_nxt; outv_r <= outv_nxt; band_r <= band_nxt; ch_r <= ch_nxt;
      step_r <= step_nxt; stage_r <= stage_nxt;
    end
    l_r <= l_nxt; r_r <= r_nxt; x_r <= x_nxt; y_r <= y_nxt; t1_r <= t1_nxt;
    ol_r <= ol_nxt; or_r <= or_nxt; ma_r <= ma_nxt; mb_r <= mb_nxt; z1_r <= z1_nxt;
  end

  assign out_valid = outv_r;
  assign out_left_out = ol_r;
  assign out_right_out = or_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_out))
    else $error("result word changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_out != 16'sh8000) else $error("output out of range");
endmodule
